// ----- design/page_bitmap_refcount_allocator_top_assert.svh -----
// Assertion macros for the page allocator
`ifndef PAGE_BITMAP_REFCOUNT_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_BITMAP_REFCOUNT_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PBA_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("pba assertion failed");
`define PBA_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("pba assertion failed");
`else
`define PBA_ASSERT_IMPL(lbl, a, b)
`define PBA_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- design/pba_pkg.sv -----
package pba_pkg;
    localparam int MaxPages   = 4096;
    localparam int PageShift  = 12;
    localparam int WordBits   = 64;
    localparam int CountWidth = 16;
    localparam int NumWords   = MaxPages / WordBits;
    localparam int PageW      = $clog2(MaxPages);
    localparam int WordW      = $clog2(NumWords);
    localparam int BitW       = $clog2(WordBits);

    typedef enum logic [2:0] {
        REQ_ALLOC_ONE = 3'd0,
        REQ_ALLOC_RUN = 3'd1,
        REQ_ADD_REFS  = 3'd2,
        REQ_DROP_REFS = 3'd3,
        REQ_READ      = 3'd4,
        REQ_RESERVE   = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_RANGE     = 3'd2,
        ST_ZERO_LEN  = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    localparam logic [CountWidth-1:0] CountMax = '1;
endpackage

// ----- design/pba_bitmap_ram.sv -----
// Used bitmap: one word per row, registered read, valid bit per row
module pba_bitmap_ram (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [pba_pkg::WordW-1:0]             raddr,
    output logic [pba_pkg::WordBits-1:0]          rdata,
    input  logic                                  we,
    input  logic [pba_pkg::WordW-1:0]             waddr,
    input  logic [pba_pkg::WordBits-1:0]          wdata
);
    logic [pba_pkg::WordBits-1:0] mem [pba_pkg::NumWords];
    logic [pba_pkg::NumWords-1:0] valid_reg;
    logic [pba_pkg::WordBits-1:0] data_reg;
    logic                         hit_reg;

    // write a row, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        data_reg <= mem[raddr];
    end

    // track written rows so unwritten rows read as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            hit_reg <= valid_reg[raddr];
        end
    end

    assign rdata = hit_reg ? data_reg : '0;
endmodule

// ----- design/pba_count_ram.sv -----
// Reference counts, one entry per page, registered read
module pba_count_ram (
    input  logic                              clk,
    input  logic [pba_pkg::PageW-1:0]         raddr,
    output logic [pba_pkg::CountWidth-1:0]    rdata,
    input  logic                              we,
    input  logic [pba_pkg::PageW-1:0]         waddr,
    input  logic [pba_pkg::CountWidth-1:0]    wdata
);
    logic [pba_pkg::CountWidth-1:0] mem [pba_pkg::MaxPages];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/page_bitmap_refcount_allocator_top.sv -----
// Channel  | Signals                                   | Handshake
// request  | start, busy, req_type, byte_address,      | start && !busy
//          | run_length                                |
// result   | done, result_address, found, pages_touched,| done, one cycle
//          | count_value, used_total, status           |
// config   | cfg_valid, cfg_ready, cfg_data            | cfg_valid && cfg_ready
// One page per step: a step reads the bitmap word and the count of the page
// (registered memory read) in S_READ, then evaluates them in S_EVAL and writes back what
// the request changes; done is raised in the cycle after the last page is evaluated.
// Alloc run then marks each page of the found run used: S_FILL reads it and
// S_FILLW writes the bitmap bit and a count of one.
// Zero-length, out-of-range and unknown requests raise done right after accept.
// Reset clears the bitmap row valid bits at once; no clearing pass.
// Results cannot be stalled; busy stays high from accept through done.
module page_bitmap_refcount_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [23:0] byte_address,
    input  logic [12:0] run_length,
    output logic        done,
    output logic [23:0] result_address,
    output logic        found,
    output logic [12:0] pages_touched,
    output logic [15:0] count_value,
    output logic [12:0] used_total,
    output logic [2:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);
    localparam int PW = pba_pkg::PageW;
    localparam int CW = pba_pkg::CountWidth;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_FILL  = 6'b001000,
        S_FILLW = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [12:0]     range_reg;
    logic [2:0]      req_reg;
    logic [12:0]     len_reg;
    logic [12:0]     total_reg;
    logic [12:0]     page_reg, page_next;
    logic [12:0]     end_reg;
    logic [12:0]     first_reg, first_next;
    logic [12:0]     run_reg, run_next;
    logic [12:0]     touched_reg, touched_next;
    logic [12:0]     used_reg, used_next;
    logic [CW-1:0]   cval_reg, cval_next;
    logic [2:0]      status_reg, status_next;
    logic            found_reg, found_next;

    logic [pba_pkg::WordBits-1:0] bm_rdata, bm_wdata;
    logic [CW-1:0]   cnt_rdata, cnt_wdata;
    logic            bm_we, cnt_we;
    logic [PW-1:0]   rd_page;
    logic            used_bit;
    logic [12:0]     req_page, total_c;
    logic [13:0]     run_end;

    assign req_page   = {1'b0, byte_address[23:pba_pkg::PageShift]};
    assign total_c    = (range_reg > 13'(pba_pkg::MaxPages)) ?
                        13'(pba_pkg::MaxPages) : range_reg;
    assign run_end    = {1'b0, req_page} + {1'b0, run_length};
    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);

    // memory read goes to the current page; writes land after evaluation
    assign rd_page  = page_reg[PW-1:0];
    assign used_bit = bm_rdata[page_reg[pba_pkg::BitW-1:0]];

    pba_bitmap_ram u_bm (
        .clk(clk), .rst_n(rst_n),
        .raddr(rd_page[PW-1:pba_pkg::BitW]), .rdata(bm_rdata),
        .we(bm_we), .waddr(rd_page[PW-1:pba_pkg::BitW]), .wdata(bm_wdata)
    );

    pba_count_ram u_cnt (
        .clk(clk), .raddr(rd_page), .rdata(cnt_rdata),
        .we(cnt_we), .waddr(rd_page), .wdata(cnt_wdata)
    );

    // step logic: evaluate one page per S_EVAL
    always_comb
    begin
        state_next   = state_reg;
        page_next    = page_reg;
        first_next   = first_reg;
        run_next     = run_reg;
        touched_next = touched_reg;
        used_next    = used_reg;
        cval_next    = cval_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        bm_we        = 1'b0;
        cnt_we       = 1'b0;
        bm_wdata     = bm_rdata;
        cnt_wdata    = cnt_rdata;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next   = S_READ;
                    touched_next = '0;
                    cval_next    = '0;
                    found_next   = 1'b0;
                    run_next     = '0;
                    first_next   = '0;
                    status_next  = pba_pkg::ST_OK;
                    page_next    = '0;
                    unique case (req_type)
                        pba_pkg::REQ_ALLOC_ONE:
                        begin
                            status_next = pba_pkg::ST_NO_SPACE;
                            if (total_c == 13'd0) state_next = S_DONE;
                        end
                        pba_pkg::REQ_ALLOC_RUN:
                        begin
                            if (run_length == 13'd0)
                            begin
                                status_next = pba_pkg::ST_ZERO_LEN;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                status_next = pba_pkg::ST_NO_SPACE;
                                if (total_c == 13'd0) state_next = S_DONE;
                            end
                        end
                        pba_pkg::REQ_ADD_REFS, pba_pkg::REQ_DROP_REFS,
                        pba_pkg::REQ_RESERVE:
                        begin
                            page_next = req_page;
                            if (run_length == 13'd0)
                            begin
                                status_next = pba_pkg::ST_ZERO_LEN;
                                state_next  = S_DONE;
                            end
                            else if (req_page >= total_c ||
                                     run_end > {1'b0, total_c})
                            begin
                                status_next = pba_pkg::ST_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        pba_pkg::REQ_READ:
                        begin
                            page_next = req_page;
                            if (req_page >= total_c)
                            begin
                                status_next = pba_pkg::ST_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_READ: state_next = S_EVAL;
            S_EVAL:
            begin
                state_next = S_READ;
                page_next  = page_reg + 13'd1;
                unique case (req_reg)
                    pba_pkg::REQ_ALLOC_ONE:
                    begin
                        if (!used_bit)
                        begin
                            bm_we       = 1'b1;
                            bm_wdata[page_reg[pba_pkg::BitW-1:0]] = 1'b1;
                            cnt_we      = 1'b1;
                            cnt_wdata   = CW'(1);
                            used_next   = used_reg + 13'd1;
                            found_next  = 1'b1;
                            status_next = pba_pkg::ST_OK;
                            first_next  = page_reg;
                            state_next  = S_DONE;
                        end
                        else if (page_reg + 13'd1 >= total_reg)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    pba_pkg::REQ_ALLOC_RUN:
                    begin
                        if (used_bit)
                        begin
                            run_next = '0;
                        end
                        else
                        begin
                            if (run_reg == 13'd0) first_next = page_reg;
                            run_next = run_reg + 13'd1;
                        end
                        if (!used_bit && run_reg + 13'd1 == len_reg)
                        begin
                            found_next  = 1'b1;
                            status_next = pba_pkg::ST_OK;
                            page_next   = (run_reg == 13'd0) ? page_reg : first_reg;
                            state_next  = S_FILL;
                        end
                        else if (page_reg + 13'd1 >= total_reg)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    pba_pkg::REQ_ADD_REFS:
                    begin
                        if (used_bit)
                        begin
                            touched_next = touched_reg + 13'd1;
                            if (cnt_rdata == pba_pkg::CountMax)
                                status_next = pba_pkg::ST_SATURATED;
                            else
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_rdata + CW'(1);
                            end
                        end
                        if (page_reg + 13'd1 >= end_reg) state_next = S_DONE;
                    end
                    pba_pkg::REQ_DROP_REFS:
                    begin
                        if (used_bit)
                        begin
                            touched_next = touched_reg + 13'd1;
                            cnt_we = 1'b1;
                            if (cnt_rdata <= CW'(1))
                            begin
                                bm_we     = 1'b1;
                                bm_wdata[page_reg[pba_pkg::BitW-1:0]] = 1'b0;
                                cnt_wdata = '0;
                                used_next = used_reg - 13'd1;
                            end
                            else
                                cnt_wdata = cnt_rdata - CW'(1);
                        end
                        if (page_reg + 13'd1 >= end_reg) state_next = S_DONE;
                    end
                    pba_pkg::REQ_RESERVE:
                    begin
                        if (!used_bit)
                        begin
                            touched_next = touched_reg + 13'd1;
                            bm_we     = 1'b1;
                            bm_wdata[page_reg[pba_pkg::BitW-1:0]] = 1'b1;
                            cnt_we    = 1'b1;
                            cnt_wdata = CW'(1);
                            used_next = used_reg + 13'd1;
                        end
                        if (page_reg + 13'd1 >= end_reg) state_next = S_DONE;
                    end
                    default:
                    begin
                        if (used_bit) cval_next = cnt_rdata;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FILL: state_next = S_FILLW;
            S_FILLW:
            begin
                // mark one page of the found run used
                bm_we     = 1'b1;
                bm_wdata[page_reg[pba_pkg::BitW-1:0]] = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = CW'(1);
                used_next = used_reg + 13'd1;
                page_next = page_reg + 13'd1;
                state_next = (page_reg + 13'd1 >= end_reg) ? S_DONE : S_FILL;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            range_reg <= 13'(pba_pkg::MaxPages);
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (cfg_valid && cfg_ready) range_reg <= cfg_data;
        end
    end

    // per-request working registers
    always_ff @(posedge clk)
    begin
        page_reg    <= page_next;
        first_reg   <= first_next;
        run_reg     <= run_next;
        touched_reg <= touched_next;
        cval_reg    <= cval_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        if (state_reg == S_IDLE && start)
        begin
            req_reg   <= req_type;
            len_reg   <= run_length;
            total_reg <= total_c;
            end_reg   <= run_end[12:0];
        end
        else if (state_reg == S_EVAL && state_next == S_FILL)
        begin
            end_reg <= page_reg + 13'd1;
        end
    end

    // result beat
    assign done           = (state_reg == S_DONE);
    assign found          = found_reg;
    assign result_address = found_reg ?
        {first_reg[PW-1:0], pba_pkg::PageShift'(0)} : 24'd0;
    assign pages_touched  = touched_reg;
    assign count_value    = cval_reg;
    assign used_total     = used_reg;
    assign status         = status_reg;

`include "page_bitmap_refcount_allocator_top_assert.svh"
    `PBA_ASSERT_IMPL(a_done_busy, done, busy)
    `PBA_ASSERT_NEXT(a_done_idle, done, !busy)
    `PBA_ASSERT_IMPL(a_found_ok, done && found, status == 3'(pba_pkg::ST_OK))
    `PBA_ASSERT_IMPL(a_used_bound, 1'b1, used_total <= 13'(pba_pkg::MaxPages))
endmodule
